/* rtl/igemv_pkg.sv */
// shared types and constants for the int8 gemv core
`timescale 1ns / 1ps
`default_nettype none

package igemv_pkg;

  localparam int MaxColumnsDef = 4096;
  localparam int RowLenW       = 13;
  localparam int PosW          = 12;
  localparam int ValueW        = 8;
  localparam int DataW         = 32;
  localparam int CfgIdxW       = 2;
  localparam int ProdW         = 2 * ValueW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRowLength = 2'd0,
    CfgAlpha     = 2'd1,
    CfgBeta      = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ActLoad   = 1'b0,
    ActMatrix = 1'b1
  } action_e;

  // finished row handed to the scaling stage
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] sum;
    logic [DataW-1:0] prior;
  } fin_t;

endpackage

`default_nettype wire

/* rtl/igemv_scale.sv */
// alpha/beta scaling stage and result register
`timescale 1ns / 1ps
`default_nettype none

module igemv_scale import igemv_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    hold_i,
  input  wire fin_t                    fin_i,
  input  wire logic        [DataW-1:0] alpha_i,
  input  wire logic        [DataW-1:0] beta_i,
  output logic                         out_valid_o,
  output logic signed      [DataW-1:0] y_out_o
);

  logic             mul_valid_q;
  logic [DataW-1:0] mul_a_q, mul_a_d;
  logic [DataW-1:0] mul_b_q, mul_b_d;
  logic             out_valid_q;
  logic [DataW-1:0] y_q;

  // low halves only, wrap modulo 2^32
  assign mul_a_d = alpha_i * fin_i.sum;
  assign mul_b_d = beta_i * fin_i.prior;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (!hold_i) begin
      mul_valid_q <= fin_i.valid;
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold_i) begin
      if (fin_i.valid) begin
        mul_a_q <= mul_a_d;
        mul_b_q <= mul_b_d;
      end
      if (mul_valid_q) begin
        y_q <= mul_a_q + mul_b_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign y_out_o     = y_q;

endmodule

`default_nettype wire

/* rtl/int8_gemv_alpha_beta_core.sv */
// int8 gemv core: y = alpha*A*x + beta*y with a vector store and row accumulator
// a row's last matrix item passes the read, product, row sum, scale and result registers
// throughput: one item per cycle, load or matrix, set by the single-read vector store
//   and one multiply-accumulate per cycle; a stalled result holds the whole pipeline
// reset: column count, row sum, pipeline valids and config registers are cleared
//   (row_length 1, alpha 1, beta 0); the vector store is not cleared, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module int8_gemv_alpha_beta_core import igemv_pkg::*; #(
  parameter int MAX_COLUMNS = MaxColumnsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // input item channel
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      action_i,
  input  wire logic        [PosW-1:0]    position_i,
  input  wire logic signed [ValueW-1:0]  value_i,
  input  wire logic signed [DataW-1:0]   prior_y_i,
  // result channel
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed      [DataW-1:0]   y_out_o,
  // configuration write channel
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic        [CfgIdxW-1:0] cfg_index_i,
  input  wire logic        [DataW-1:0]   cfg_data_i
);

  localparam int IdxW    = $clog2(MAX_COLUMNS);
  localparam int LenW    = $clog2(MAX_COLUMNS + 1);
  localparam int CmpW    = (LenW > RowLenW) ? LenW : RowLenW;
  // wide enough to hold MAX_COLUMNS itself for the range check
  localparam int PosExtW = (LenW > PosW) ? LenW : PosW;

  // configuration registers
  logic [RowLenW-1:0] row_length_q;
  logic [DataW-1:0]   alpha_q;
  logic [DataW-1:0]   beta_q;

  // whole pipeline freezes while a finished result waits
  logic hold;
  logic accept, acc_load, acc_mat;

  // row length after the zero and max clamps
  logic [CmpW-1:0] rl_ext;
  logic [LenW-1:0] len_eff;
  logic [IdxW-1:0] last_col;
  logic [IdxW-1:0] col_q, col_d;
  logic [IdxW-1:0] rd_col;
  logic            is_last;

  // load address check
  logic [PosExtW-1:0] pos_ext;
  logic               pos_ok;
  logic [IdxW-1:0]    wr_addr;

  // vector store, one write and one registered read per cycle
  logic signed [ValueW-1:0] vstore_q [MAX_COLUMNS];
  logic signed [ValueW-1:0] rd_q;

  // stage 1: store read in flight
  logic                     s1_valid_q;
  logic signed [ValueW-1:0] s1_val_q;
  logic [DataW-1:0]         s1_prior_q;
  logic                     s1_last_q;

  // stage 2: product registered
  logic signed [ProdW-1:0]  prod;
  logic signed [ProdW-1:0]  s2_prod_q;
  logic                     s2_valid_q;
  logic [DataW-1:0]         s2_prior_q;
  logic                     s2_last_q;

  // stage 3: row accumulation
  logic [DataW-1:0] row_sum_q;
  logic [DataW-1:0] sum_new;
  logic             fin_valid_q;
  logic [DataW-1:0] fin_sum_q;
  logic [DataW-1:0] fin_prior_q;
  fin_t             fin;

  assign hold        = out_valid_o && out_stall_i;
  assign in_stall_o  = hold;
  assign cfg_ready_o = 1'b1;

  assign accept   = in_valid_i && !in_stall_o;
  assign acc_load = accept && (action_i == ActLoad);
  assign acc_mat  = accept && (action_i == ActMatrix);

  // config writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= RowLenW'(1);
      alpha_q      <= DataW'(1);
      beta_q       <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgRowLength: row_length_q <= cfg_data_i[RowLenW-1:0];
        CfgAlpha:     alpha_q      <= cfg_data_i;
        CfgBeta:      beta_q       <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign rl_ext = CmpW'(row_length_q);

  always_comb begin
    if (row_length_q == '0) begin
      len_eff = LenW'(1);
    end else if (rl_ext > CmpW'(MAX_COLUMNS)) begin
      len_eff = LenW'(MAX_COLUMNS);
    end else begin
      len_eff = LenW'(rl_ext);
    end
  end

  assign last_col = IdxW'(len_eff - LenW'(1));
  // a column at or past the end (length shrunk mid-row) closes the row
  assign is_last  = (col_q >= last_col);
  assign rd_col   = is_last ? last_col : col_q;
  assign col_d    = is_last ? '0 : col_q + IdxW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (acc_mat) begin
      col_q <= col_d;
    end
  end

  // loads beyond the store are ignored
  assign pos_ext = PosExtW'(position_i);
  assign pos_ok  = pos_ext < PosExtW'(MAX_COLUMNS);
  assign wr_addr = IdxW'(position_i);

  // a load and a read never share an edge, so no forwarding is needed:
  // a read issued the cycle after a load already sees the new entry
  always_ff @(posedge clk_i) begin
    if (acc_load && pos_ok) begin
      vstore_q[wr_addr] <= value_i;
    end
    if (acc_mat) begin
      rd_q <= vstore_q[rd_col];
    end
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      fin_valid_q <= 1'b0;
      row_sum_q   <= '0;
    end else if (!hold) begin
      s1_valid_q  <= acc_mat;
      s2_valid_q  <= s1_valid_q;
      fin_valid_q <= s2_valid_q && s2_last_q;
      if (s2_valid_q) begin
        row_sum_q <= s2_last_q ? '0 : sum_new;
      end
    end
  end

  assign prod    = s1_val_q * rd_q;
  assign sum_new = row_sum_q + DataW'(s2_prod_q);

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (acc_mat) begin
      s1_val_q   <= value_i;
      s1_prior_q <= prior_y_i;
      s1_last_q  <= is_last;
    end
    if (!hold) begin
      if (s1_valid_q) begin
        s2_prod_q  <= prod;
        s2_prior_q <= s1_prior_q;
        s2_last_q  <= s1_last_q;
      end
      if (s2_valid_q && s2_last_q) begin
        fin_sum_q   <= sum_new;
        fin_prior_q <= s2_prior_q;
      end
    end
  end

  assign fin = '{valid: fin_valid_q, sum: fin_sum_q, prior: fin_prior_q};

  igemv_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hold_i      (hold),
    .fin_i       (fin),
    .alpha_i     (alpha_q),
    .beta_i      (beta_q),
    .out_valid_o (out_valid_o),
    .y_out_o     (y_out_o)
  );

  // loads never enter the multiply pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_load |=> !s1_valid_q)
    else $error("load item entered the multiply pipeline");

  // the row's last element restarts the column count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_mat && is_last) |=> (col_q == '0))
    else $error("column count not restarted after last column");

  // accumulator cleared once a row is handed on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!hold && s2_valid_q && s2_last_q) |=> (row_sum_q == '0))
    else $error("row sum not cleared at end of row");

  // a finished row is not lost while the result side is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_valid_q && hold) |=> fin_valid_q)
    else $error("finished row dropped during hold");

endmodule

`default_nettype wire
